@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the escaper drain; they compile to nothing under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLIES(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

@@ rtl/core/jse_pkg.sv @@
// Types, constants and the escape encoder function of the JSON string escaper.
`timescale 1ns / 1ps

package jse_pkg;

   localparam int unsigned SEQ_MAX = 6;
   localparam int unsigned LEN_BITS = 3;

   localparam logic [7:0] CHAR_NUL = 8'h00;
   localparam logic [7:0] CHAR_BS = 8'h08;
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_FF = 8'h0C;
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_B = 8'h62;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_LOWER_N = 8'h6E;
   localparam logic [7:0] CHAR_LOWER_R = 8'h72;
   localparam logic [7:0] CHAR_LOWER_T = 8'h74;
   localparam logic [7:0] CHAR_LOWER_U = 8'h75;
   localparam logic [7:0] CTRL_LIMIT = 8'h20;

   localparam logic [15:0] CAPACITY_RESET = 16'd256;

   typedef logic [SEQ_MAX-1:0][7:0] jse_bytes_type;

   typedef struct packed {
      jse_bytes_type        seq;
      logic [LEN_BITS-1:0]  len;
      logic                 last;
   } jse_seq_type;

   function automatic logic [7:0] hex_digit(input logic [3:0] nibble);
      logic [7:0] digit;
      if (nibble < 4'd10) begin
         digit = CHAR_ZERO + {4'h0, nibble};
      end else begin
         digit = CHAR_LOWER_A + {4'h0, nibble} - 8'd10;
      end
      return digit;
   endfunction

   // Escape sequence, or the byte itself if it needs none, for a nonzero source byte; first byte in element zero.
   function automatic jse_seq_type escape(input logic [7:0] src);
      jse_seq_type res;
      res = '0;
      res.seq[0] = CHAR_BACKSLASH;
      res.len = LEN_BITS'(2);
      unique case (src)
         CHAR_QUOTE:     res.seq[1] = CHAR_QUOTE;
         CHAR_BACKSLASH: res.seq[1] = CHAR_BACKSLASH;
         CHAR_BS:        res.seq[1] = CHAR_LOWER_B;
         CHAR_FF:        res.seq[1] = CHAR_LOWER_F;
         CHAR_LF:        res.seq[1] = CHAR_LOWER_N;
         CHAR_CR:        res.seq[1] = CHAR_LOWER_R;
         CHAR_TAB:       res.seq[1] = CHAR_LOWER_T;
         default: begin
            if (src < CTRL_LIMIT) begin
               res.seq[1] = CHAR_LOWER_U;
               res.seq[2] = CHAR_ZERO;
               res.seq[3] = CHAR_ZERO;
               res.seq[4] = hex_digit(src[7:4]);
               res.seq[5] = hex_digit(src[3:0]);
               res.len = LEN_BITS'(SEQ_MAX);
            end else begin
               res.seq[0] = src;
               res.len = LEN_BITS'(1);
            end
         end
      endcase
      return res;
   endfunction

endpackage

@@ rtl/core/jse_drain.sv @@
// Sequence buffer and output register that deliver escape bytes one per transaction.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jse_drain
   import jse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  jse_seq_type load_seq,
   output logic        can_load,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_string
);

   jse_bytes_type       seq_ff, seq_in;
   logic [LEN_BITS-1:0] rem_ff, rem_in;
   logic                last_ff, last_in;
   logic                out_valid_ff, out_valid_in;
   logic [7:0]          out_byte_ff, out_byte_in;
   logic                out_last_ff, out_last_in;
   logic                move;

   assign move = (rem_ff != '0) && (!out_valid_ff || !rsp_stall);
   assign can_load = (rem_ff == '0) || ((rem_ff == LEN_BITS'(1)) && move);

   always_comb begin
      seq_in = seq_ff;
      rem_in = rem_ff;
      last_in = last_ff;
      out_valid_in = out_valid_ff;
      out_byte_in = out_byte_ff;
      out_last_in = out_last_ff;
      if (move) begin
         out_valid_in = 1'b1;
         out_byte_in = seq_ff[0];
         out_last_in = last_ff && (rem_ff == LEN_BITS'(1));
         seq_in = {8'h00, seq_ff[SEQ_MAX-1:1]};
         rem_in = rem_ff - LEN_BITS'(1);
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      if (load) begin
         seq_in = load_seq.seq;
         rem_in = load_seq.len;
         last_in = load_seq.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         rem_ff <= rem_in;
         out_valid_ff <= out_valid_in;
      end
      seq_ff <= seq_in;
      last_ff <= last_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_last_of_string = out_last_ff;

   `ASSERT_IMPLIES(a_load_when_free, clock, reset, load, can_load)
   `ASSERT_IMPLIES(a_rem_bounded, clock, reset, 1'b1, rem_ff <= LEN_BITS'(SEQ_MAX))
   `ASSERT_IMPLIES(a_last_single, clock, reset, last_ff && (rem_ff != '0), rem_ff == LEN_BITS'(1))
   `ASSERT_NEXT(a_move_shows, clock, reset, move, out_valid_ff)

endmodule

@@ rtl/core/json_string_escaper_unit.sv @@
// Top level of the JSON string escaper: capacity register, count tracking and fit check.
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  req_src_byte
// rsp       out        rsp_valid / rsp_stall  rsp_out_byte, rsp_last_of_string
// csr       in         csr_valid / csr_ready  csr_capacity
//
// Plain bytes and the terminator flow at one byte per cycle while the output is not stalled.
// A two byte or \u escape holds the input until its last byte moves into the single
// output register. Dropped bytes are accepted without being loaded.
// Reset clears the count, the truncation flag and the buffers, and sets capacity to 256.
// A stalled output holds its byte and the input stalls once the sequence buffer is full.

module json_string_escaper_unit
   import jse_pkg::*;
#(
   parameter int unsigned COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_src_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_string,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_capacity
);

   localparam int unsigned SUM_BITS = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;

   logic [15:0]           capacity_ff;
   logic [COUNT_BITS-1:0] bytes_written_ff, bytes_written_in;
   logic                  truncated_ff, truncated_in;
   logic                  accept;
   logic                  can_load;
   logic                  load;
   jse_seq_type           enc_seq;
   jse_seq_type           load_seq;
   logic [SUM_BITS-1:0]   cap_ext;
   logic [SUM_BITS-1:0]   lim_ext;
   logic [SUM_BITS-1:0]   eff_cap;
   logic [SUM_BITS-1:0]   need;
   logic                  fits;

   assign csr_ready = 1'b1;
   assign req_stall = !can_load;
   assign accept = req_valid && !req_stall;

   assign cap_ext = SUM_BITS'(capacity_ff);
   assign lim_ext = SUM_BITS'({COUNT_BITS{1'b1}});
   assign eff_cap = (cap_ext < lim_ext) ? cap_ext : lim_ext;
   assign enc_seq = escape(req_src_byte);
   assign need = SUM_BITS'(bytes_written_ff) + SUM_BITS'(enc_seq.len);
   assign fits = need < eff_cap;

   always_comb begin
      bytes_written_in = bytes_written_ff;
      truncated_in = truncated_ff;
      load = 1'b0;
      load_seq = enc_seq;
      if (accept) begin
         if (req_src_byte == CHAR_NUL) begin
            bytes_written_in = '0;
            truncated_in = 1'b0;
            load = (capacity_ff != '0);
            load_seq = '0;
            load_seq.seq[0] = CHAR_NUL;
            load_seq.len = LEN_BITS'(1);
            load_seq.last = 1'b1;
         end else if ((capacity_ff != '0) && !truncated_ff) begin
            if (fits) begin
               load = 1'b1;
               bytes_written_in = bytes_written_ff + COUNT_BITS'(enc_seq.len);
            end else begin
               truncated_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
         bytes_written_ff <= '0;
         truncated_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            capacity_ff <= csr_capacity;
         end
         bytes_written_ff <= bytes_written_in;
         truncated_ff <= truncated_in;
      end
   end

   jse_drain u_drain (
      .clock              (clock),
      .reset              (reset),
      .load               (load),
      .load_seq           (load_seq),
      .can_load           (can_load),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last_of_string (rsp_last_of_string)
   );

endmodule
